>>> src/sha256_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 byte hasher package
// Payload types, round constants and the SHA-256 word functions.
// ----------------------------------------------------------------------------
package sha256_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha_out_t;

  // Source of a block byte written into the buffer.
  typedef enum logic [1:0] {
    BSRC_DATA = 2'd0,
    BSRC_PAD  = 2'd1,
    BSRC_ZERO = 2'd2,
    BSRC_LEN  = 2'd3
  } sha_bsrc_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic      buf_wr;      // write one byte into the block buffer
    sha_bsrc_t buf_src;
    logic      cnt_clr;     // clear the byte total (new message)
    logic      cnt_inc;     // count one message byte
    logic      comp_start;  // load working vars from chain
    logic      round_en;    // run one round
    logic      comp_end;    // fold working vars into chain
    logic      chain_init;  // restore the initial hash
    logic      out_load;    // load digest word into output register
  } sha_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic [5:0] fill;
    logic [5:0] round;
    logic       out_busy;
    logic       out_taken;
    logic [2:0] out_idx;
  } sha_sts_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    big_s0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    big_s1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_s0(input logic [31:0] x);
    small_s0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_s1(input logic [31:0] x);
    small_s1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

>>> src/sha256_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Block buffer, byte total, schedule window, round unit, chain and output reg.
// ----------------------------------------------------------------------------
module sha256_datapath import sha256_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic [7:0] in_byte,
  input  sha_cmd_t cmd,
  output sha_sts_t sts,
  input  logic     out_stall,
  output logic     out_valid,
  output sha_out_t out_data
);

  // Block buffer kept as 16 big-endian words; bytes land by lane.
  logic [31:0] buf_mem [16];
  logic [5:0]  fill_r;
  logic [60:0] total_r;
  logic [5:0]  round_r;
  logic [31:0] win_r [16];
  logic [31:0] wv_r [8];
  logic [31:0] chain_r [8];
  logic [2:0]  oidx_r;
  logic        ovalid_r;
  sha_out_t    odata_r;

  logic [7:0]  wr_byte;
  logic [63:0] bit_len;
  logic [2:0]  len_sel;
  logic [31:0] w_buf, w_sched, w_cur, t1, t2;

  assign bit_len = {total_r, 3'b000};
  assign len_sel = fill_r[2:0];

  always_comb begin
    unique case (cmd.buf_src)
      BSRC_DATA: wr_byte = in_byte;
      BSRC_PAD:  wr_byte = PAD_BYTE;
      BSRC_ZERO: wr_byte = 8'h00;
      BSRC_LEN:  wr_byte = bit_len[(7 - len_sel) * 8 +: 8];
      default:   wr_byte = 8'h00;
    endcase
  end

  // Message word for the first 16 rounds.
  assign w_buf = buf_mem[round_r[3:0]];
  assign w_sched = small_s1(win_r[14]) + win_r[9] + small_s0(win_r[1]) + win_r[0];
  assign w_cur = round_r[5:4] == 2'd0 ? w_buf : w_sched;
  assign t1 = wv_r[7] + big_s1(wv_r[4]) + ((wv_r[4] & wv_r[5]) ^ (~wv_r[4] & wv_r[6]))
              + ROUND_K[round_r] + w_cur;
  assign t2 = big_s0(wv_r[0]) + ((wv_r[0] & wv_r[1]) ^ (wv_r[0] & wv_r[2])
              ^ (wv_r[1] & wv_r[2]));

  always_ff @(posedge clk) begin
    if (cmd.buf_wr) buf_mem[fill_r[5:2]][(3 - fill_r[1:0]) * 8 +: 8] <= wr_byte;
    if (cmd.comp_start) begin
      for (int i = 0; i < 8; i++) wv_r[i] <= chain_r[i];
    end else if (cmd.round_en) begin
      wv_r[0] <= t1 + t2;
      wv_r[1] <= wv_r[0];
      wv_r[2] <= wv_r[1];
      wv_r[3] <= wv_r[2];
      wv_r[4] <= wv_r[3] + t1;
      wv_r[5] <= wv_r[4];
      wv_r[6] <= wv_r[5];
      wv_r[7] <= wv_r[6];
      // Window shifts: win_r[15] holds the newest word.
      for (int i = 0; i < 15; i++) win_r[i] <= win_r[i + 1];
      win_r[15] <= w_cur;
    end
    if (cmd.out_load) odata_r <= '{digest_word: chain_r[oidx_r], word_index: oidx_r,
                                   last_word: oidx_r == 3'd7};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      total_r <= '0;
      round_r <= '0;
      oidx_r <= '0;
      ovalid_r <= 1'b0;
      for (int i = 0; i < 8; i++) chain_r[i] <= IV[i];
    end else begin
      if (cmd.buf_wr) fill_r <= fill_r + 6'd1;
      if (cmd.cnt_clr) total_r <= '0;
      else if (cmd.cnt_inc) total_r <= total_r + 61'd1;
      if (cmd.comp_start) round_r <= '0;
      else if (cmd.round_en) round_r <= round_r + 6'd1;
      if (cmd.chain_init) begin
        for (int i = 0; i < 8; i++) chain_r[i] <= IV[i];
      end else if (cmd.comp_end) begin
        for (int i = 0; i < 8; i++) chain_r[i] <= chain_r[i] + wv_r[i];
      end
      if (cmd.out_load) begin
        ovalid_r <= 1'b1;
        oidx_r <= oidx_r + 3'd1;
      end else if (ovalid_r && !out_stall) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  assign sts = '{fill: fill_r, round: round_r, out_busy: ovalid_r,
                 out_taken: ovalid_r && !out_stall, out_idx: oidx_r};
  assign out_valid = ovalid_r;
  assign out_data = odata_r;

endmodule

>>> src/sha256_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences byte loads, padding, compressions and digest output.
// ----------------------------------------------------------------------------
module sha256_ctrl import sha256_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  sha_in_t  in_data,
  output logic     in_stall,
  input  sha_sts_t sts,
  output sha_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_ROUND, S_FOLD, S_PAD, S_LEN, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   final_r, final_nxt;     // padding pending after this compression
  logic   padded_r, padded_nxt;   // the 0x80 has been placed
  logic   lendone_r, lendone_nxt; // length bytes written, last block in flight
  logic   acc;

  assign in_stall = state_r != S_IDLE;
  assign acc = in_valid && state_r == S_IDLE;

  always_comb begin
    state_nxt = state_r;
    final_nxt = final_r;
    padded_nxt = padded_r;
    lendone_nxt = lendone_r;
    cmd = '0;
    cmd.buf_src = BSRC_DATA;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (in_data.byte_valid) begin
            cmd.buf_wr = 1'b1;
            cmd.cnt_inc = 1'b1;
          end
          final_nxt = in_data.end_of_message;
          padded_nxt = 1'b0;
          lendone_nxt = 1'b0;
          if (in_data.byte_valid && sts.fill == 6'd63) state_nxt = S_START;
          else if (in_data.end_of_message) state_nxt = S_PAD;
        end
      end
      S_START: begin
        cmd.comp_start = 1'b1;
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        cmd.round_en = 1'b1;
        if (sts.round == 6'd63) state_nxt = S_FOLD;
      end
      S_FOLD: begin
        cmd.comp_end = 1'b1;
        if (!final_r) state_nxt = S_IDLE;
        else if (lendone_r) state_nxt = S_OUT;  // digest ready next cycle
        else state_nxt = S_PAD;
      end
      S_PAD: begin
        cmd.buf_wr = 1'b1;
        if (!padded_r) begin
          cmd.buf_src = BSRC_PAD;
          padded_nxt = 1'b1;
        end else begin
          cmd.buf_src = BSRC_ZERO;
        end
        if (sts.fill == 6'd63) state_nxt = S_START;
        else if (sts.fill == 6'd55) state_nxt = S_LEN;
      end
      S_LEN: begin
        cmd.buf_wr = 1'b1;
        cmd.buf_src = BSRC_LEN;
        if (sts.fill == 6'd63) begin
          state_nxt = S_START;
          lendone_nxt = 1'b1;
        end
      end
      S_OUT: begin
        if (!sts.out_busy || sts.out_taken) begin
          cmd.out_load = 1'b1;
          if (sts.out_idx == 3'd7) begin
            state_nxt = S_IDLE;
            cmd.chain_init = 1'b1;
            cmd.cnt_clr = 1'b1;
            final_nxt = 1'b0;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      final_r <= 1'b0;
      padded_r <= 1'b0;
      lendone_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      final_r <= final_nxt;
      padded_r <= padded_nxt;
      lendone_r <= lendone_nxt;
    end
  end

endmodule

>>> src/sha256_byte_stream_hasher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Top level: controller plus datapath.
// ----------------------------------------------------------------------------
// Hashes a message fed one word (byte) per handshake; an end_of_message word,
// with or without a byte, pads the message and yields eight 32-bit digest
// words, index 0 first, last_word on index 7. A byte that fills a 64-byte
// block starts a compression (load, 64 rounds, fold) in the single round
// unit, and no new byte is taken until that block is folded in. Ending a
// message costs the padding byte writes (one per cycle up to the block end),
// one or two compressions, then eight output words. The input is stalled
// whenever the block is working; the digest leaves through an output
// register and the block returns to idle after the eighth word is loaded.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher import sha256_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  sha_in_t  in_data,
  output logic     in_stall,
  output logic     out_valid,
  output sha_out_t out_data,
  input  logic     out_stall
);

  sha_cmd_t cmd;
  sha_sts_t sts;

  sha256_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_data, .in_stall, .sts, .cmd
  );

  sha256_datapath u_dp (
    .clk, .rst_n, .in_byte(in_data.data_byte), .cmd, .sts,
    .out_stall, .out_valid, .out_data
  );

endmodule

>>> src/sha256_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 port checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
module sha256_checker import sha256_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input sha_in_t  in_data,
  input logic     in_stall,
  input logic     out_valid,
  input sha_out_t out_data,
  input logic     out_stall
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input word changed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled digest word changed");

  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.last_word == (out_data.word_index == 3'd7))
    else $error("last_word mismatch");

  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall ##1 out_valid && !$stable(out_data.word_index) |->
    out_data.word_index == $past(out_data.word_index) + 3'd1)
    else $error("digest word order broken");

  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.word_index != 3'd7 |-> in_stall)
    else $error("input open mid-digest");

endmodule

bind sha256_byte_stream_hasher sha256_checker u_chk (.*);

>>> test/sha256_byte_stream_hasher_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher testbench
// Feeds byte words with random gaps and output stalls, predicts each digest
// with a behavioral SHA-256 and checks every digest word in order.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_test;
  import sha256_pkg::*;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  sha_in_t  in_data = '0;
  logic     in_stall;
  logic     out_valid;
  sha_out_t out_data;
  logic     out_stall = 1'b0;

  always #5 clk = ~clk;

  sha256_byte_stream_hasher u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_data(in_data), .in_stall(in_stall),
    .out_valid(out_valid), .out_data(out_data), .out_stall(out_stall)
  );

  // Predictor state: chaining words, block buffer, fill and byte total.
  logic [31:0] chain [8];
  logic [7:0]  blk [64];
  int          fill;
  logic [60:0] byte_total;
  sha_out_t    digest_q [$];

  int errors = 0;
  int words_seen = 0;
  int msgs_sent = 0;
  int items_sent = 0;
  bit gaps_on = 1'b1;     // random idling on both sides
  int hold_cycles = 0;    // forced long receiver hold-off
  int stall_left = 0;     // remaining cycles of a random stall burst

  localparam logic [31:0] H0 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One 64-round compression of blk into chain.
  task automatic compress_blk();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int r = 0; r < 64; r++) begin
      if (r < 16) begin
        w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
      end else begin
        w[r] = (ror(w[r-2], 17) ^ ror(w[r-2], 19) ^ (w[r-2] >> 10)) + w[r-7] +
               (ror(w[r-15], 7) ^ ror(w[r-15], 18) ^ (w[r-15] >> 3)) + w[r-16];
      end
    end
    {a, b, c, d, e, f, g, h} = {chain[0], chain[1], chain[2], chain[3],
                                chain[4], chain[5], chain[6], chain[7]};
    for (int r = 0; r < 64; r++) begin
      t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g)) +
           ROUND_K[r] + w[r];
      t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
  endtask

  task automatic hash_reset();
    foreach (chain[i]) chain[i] = H0[i];
    fill = 0;
    byte_total = '0;
  endtask

  // Apply one accepted word; queue eight digest words on an end mark.
  task automatic hash_word(input sha_in_t it);
    logic [63:0] bits;
    sha_out_t o;
    if (it.byte_valid) begin
      blk[fill] = it.data_byte;
      fill++;
      byte_total++;
      if (fill == 64) begin
        compress_blk();
        fill = 0;
      end
    end
    if (!it.end_of_message) return;
    bits = {byte_total, 3'b000};
    blk[fill] = 8'h80;
    fill++;
    if (fill > 56) begin
      while (fill < 64) blk[fill++] = 8'h00;
      compress_blk();
      fill = 0;
    end
    while (fill < 56) blk[fill++] = 8'h00;
    for (int i = 0; i < 8; i++) blk[56+i] = bits[63-8*i -: 8];
    compress_blk();
    for (int i = 0; i < 8; i++) begin
      o.digest_word = chain[i];
      o.word_index = i[2:0];
      o.last_word = (i == 7);
      digest_q = {digest_q, o};
    end
    hash_reset();
  endtask

  task automatic report(input string what, input logic [31:0] got,
                        input logic [31:0] want);
    $display("MISMATCH %s: got %h want %h (word %0d)", what, got, want, words_seen);
    errors++;
  endtask

  // Send one word: optional gap, then hold until accepted. Valid stays up
  // after acceptance; the next word, a gap or a pause takes it over.
  task automatic send_word(input logic [7:0] b, input bit v, input bit eom);
    sha_in_t it;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    it.data_byte = b;
    it.byte_valid = v;
    it.end_of_message = eom;
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    hash_word(it);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) begin
      // Now and then an ignored idle word inside the message.
      if ($urandom_range(0, 15) == 0) send_word(8'($urandom), 1'b0, 1'b0);
      if (i == len - 1 && $urandom_range(0, 1))
        send_word(8'($urandom), 1'b1, 1'b1);
      else
        send_word(8'($urandom), 1'b1, 1'b0);
    end
    if (len == 0 || !in_data.end_of_message) send_word(8'($urandom), 1'b0, 1'b1);
    msgs_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (digest_q.size() != 0) @(negedge clk);
  endtask

  // Directed: empty message, "abc", field extremes.
  task automatic test_directed();
    send_word(8'h00, 1'b0, 1'b1);
    send_word(8'h61, 1'b1, 1'b0);
    send_word(8'h62, 1'b1, 1'b0);
    send_word(8'h63, 1'b1, 1'b1);
    send_word(8'hff, 1'b0, 1'b0);
    send_word(8'hff, 1'b1, 1'b1);
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'h55, 1'b0, 1'b1);
    msgs_sent += 4;
    wait_drained();
  endtask

  // Lengths around 55/56/64 bytes, where padding spills into a second block.
  task automatic test_pad_edges();
    int lens [4] = '{55, 56, 63, 64};
    foreach (lens[i]) send_message(lens[i]);
  endtask

  // Receiver holds off while the sender keeps offering.
  task automatic test_backpressure();
    hold_cycles = 300;
    send_message(3);
    send_message(1);
    send_message(0);
    wait_drained();
  endtask

  task automatic test_random();
    int target;
    target = items_sent + 80;
    while (items_sent < target) send_message($urandom_range(0, 20));
  endtask

  task automatic test_no_gaps();
    gaps_on = 1'b0;
    for (int i = 0; i < 3; i++) send_message($urandom_range(0, 20));
  endtask

  // Result checker, sampled at the rising edge.
  always @(posedge clk) begin
    sha_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      words_seen++;
      if (digest_q.size() == 0) begin
        report("unexpected word", out_data.digest_word, 32'h0);
      end else begin
        want = digest_q.pop_front();
        if (out_data.digest_word !== want.digest_word)
          report("digest_word", out_data.digest_word, want.digest_word);
        if (out_data.word_index !== want.word_index)
          report("word_index", 32'(out_data.word_index), 32'(want.word_index));
        if (out_data.last_word !== want.last_word)
          report("last_word", 32'(out_data.last_word), 32'(want.last_word));
      end
    end
  end

  // Receiver stall: forced hold-off first, else random bursts.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    #20ms;
    $display("sha256_byte_stream_hasher_test: done, errors");
    $finish;
  end

  initial begin
    hash_reset();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_pad_edges();
    wait_drained();       // sender pauses until every digest is out
    test_backpressure();
    test_random();
    test_no_gaps();
    wait_drained();
    repeat (200) @(negedge clk);
    $display("Covered %0d messages, %0d words in, %0d digest words checked.",
             msgs_sent, items_sent, words_seen);
    if (errors == 0 && digest_q.size() == 0) begin
      $display("sha256_byte_stream_hasher_test: done, clean");
    end else begin
      $display("sha256_byte_stream_hasher_test: done, errors");
    end
    $finish;
  end

endmodule
